@@ hdl/dbpfp_pkg.sv @@
`default_nettype none

package dbpfp_pkg;

	// widest lane index the fixed 32-bit plane word allows
	localparam int LANE_IDX_W = 5;
	localparam int WORD_NUM_W = 6;
	localparam int COUNT_W    = 7;
	localparam int PLANE_W    = 32;
	localparam int SAMPLE_W   = 32;
	localparam int INDEX_W    = 6;

	// controller to datapath
	typedef struct packed {
		logic                  mem_wr;    // write the accepted sample
		logic                  rd_en;     // fetch one lane from the store
		logic [LANE_IDX_W-1:0] lane;      // lane being fetched
		logic                  parity;    // channel parity of the current group
		logic                  emit;      // move one plane column to the output
		logic                  emit_err;  // present the refused-frame result
		logic [WORD_NUM_W-1:0] word_num;
		logic                  last;
	} dbpfp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;    // output register can take a result this cycle
		logic count_zero;  // channel count is zero
	} dbpfp_status_t;

endpackage

`default_nettype wire

@@ hdl/dbpfp_ctrl.sv @@
`default_nettype none

module dbpfp_ctrl
	import dbpfp_pkg::*;
#(
	parameter int SAMPLE_BITS = 32,
	parameter int PLANES_KEPT = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          req_type,
	input  wire dbpfp_status_t status,
	output dbpfp_cmd_t         cmd
);

	localparam int LW = $clog2(SAMPLE_BITS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_ERR   = 3'd4;

	logic [2:0]            state_q, state_d;
	logic [LW-1:0]         lane_q, lane_d;
	logic                  parity_q, parity_d;
	logic [WORD_NUM_W-1:0] word_q, word_d;
	logic                  in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		lane_d       = lane_q;
		parity_d     = parity_q;
		word_d       = word_q;
		cmd          = '0;
		cmd.lane     = LANE_IDX_W'(lane_q);
		cmd.parity   = parity_q;
		cmd.word_num = word_q;
		cmd.last     = (word_q == WORD_NUM_W'(2 * PLANES_KEPT - 1));
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (!req_type) begin
						cmd.mem_wr = 1'b1;
					end else if (status.count_zero) begin
						state_d = ST_ERR;
					end else begin
						state_d  = ST_LOAD;
						lane_d   = '0;
						parity_d = 1'b0;
						word_d   = '0;
					end
				end
			end
			ST_LOAD: begin
				cmd.rd_en = 1'b1;
				if (lane_q == LW'(SAMPLE_BITS - 1)) begin
					state_d = ST_DRAIN;
				end else begin
					lane_d = lane_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					word_d   = word_q + 1'b1;
					if (!parity_q && word_q == WORD_NUM_W'(PLANES_KEPT - 1)) begin
						state_d  = ST_LOAD;
						lane_d   = '0;
						parity_d = 1'b1;
					end else if (word_q == WORD_NUM_W'(2 * PLANES_KEPT - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lane_q   <= '0;
			parity_q <= 1'b0;
			word_q   <= '0;
		end else begin
			state_q  <= state_d;
			lane_q   <= lane_d;
			parity_q <= parity_d;
			word_q   <= word_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/dbpfp_datapath.sv @@
`default_nettype none

module dbpfp_datapath
	import dbpfp_pkg::*;
#(
	parameter int NUM_CHANNELS = 64,
	parameter int SAMPLE_BITS  = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dbpfp_cmd_t            cmd,
	output dbpfp_status_t              status,
	input  wire logic                  cfg_we,
	input  wire logic [COUNT_W-1:0]    cfg_data,
	input  wire logic [INDEX_W-1:0]    channel_index,
	input  wire logic [SAMPLE_W-1:0]   sample_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PLANE_W-1:0]         plane_word,
	output logic [WORD_NUM_W-1:0]      word_number,
	output logic                       frame_last,
	output logic                       no_channels
);

	localparam int CH_W = $clog2(NUM_CHANNELS);
	localparam int LW   = $clog2(SAMPLE_BITS);

	logic [SAMPLE_BITS-1:0] mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] valid_q;
	logic [COUNT_W-1:0]      count_q;

	logic [COUNT_W-1:0]     active;
	logic [COUNT_W-1:0]     rd_ch;
	logic [CH_W-1:0]        rd_addr;
	logic                   rd_keep;
	logic                   wr_ok;

	logic                   rd_s1;
	logic                   keep_s1;
	logic [LW-1:0]          lane_s1;
	logic [SAMPLE_BITS-1:0] rd_data_s1;

	logic [SAMPLE_BITS-1:0] lane_q [SAMPLE_BITS];
	logic [SAMPLE_BITS-1:0] column;

	logic                   out_valid_q;

	assign active  = (count_q > COUNT_W'(NUM_CHANNELS)) ? COUNT_W'(NUM_CHANNELS) : count_q;
	assign rd_ch   = COUNT_W'({cmd.lane[LW-1:0], cmd.parity});
	assign rd_addr = rd_ch[CH_W-1:0];
	assign rd_keep = (rd_ch < active) && valid_q[rd_addr];
	assign wr_ok   = ({1'b0, channel_index} < COUNT_W'(NUM_CHANNELS));

	assign status.out_free   = !out_valid_q || out_ready;
	assign status.count_zero = (count_q == '0);

	// channel count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(64);
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.mem_wr && wr_ok) begin
			valid_q[channel_index[CH_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok) begin
			mem[channel_index[CH_W-1:0]] <= sample_value[SAMPLE_BITS-1:0];
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		keep_s1 <= rd_keep;
		lane_s1 <= cmd.lane[LW-1:0];
	end

	// lane j holds channel 2j+parity; its top bit is plane word bit SAMPLE_BITS-1-j
	always_comb begin
		for (int j = 0; j < SAMPLE_BITS; j++) begin
			column[SAMPLE_BITS-1-j] = lane_q[j][SAMPLE_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SAMPLE_BITS; j++) begin
			if (rd_s1 && lane_s1 == LW'(j)) begin
				lane_q[j] <= keep_s1 ? rd_data_s1 : '0;
			end else if (cmd.emit) begin
				lane_q[j] <= lane_q[j] << 1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			plane_word  <= PLANE_W'(column);
			word_number <= cmd.word_num;
			frame_last  <= cmd.last;
			no_channels <= 1'b0;
		end else if (cmd.emit_err) begin
			plane_word  <= '0;
			word_number <= '0;
			frame_last  <= 1'b1;
			no_channels <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/dac_bit_plane_frame_packer.sv @@
// sample write: no result; the store takes one write a cycle while the sequencer is idle
// frame: per channel parity the lanes are fetched one by one from the one read port,
//   then PLANES_KEPT plane words follow, each once the output register has room; the
//   first word is registered once the lanes of parity 0 are all fetched
// refused frame (count zero): one result
// reset clears the control state and the per-channel valid bits (store reads zero), count to 64
`default_nettype none

module dac_bit_plane_frame_packer
	import dbpfp_pkg::*;
#(
	parameter int NUM_CHANNELS = 64,
	parameter int SAMPLE_BITS  = 32,
	parameter int PLANES_KEPT  = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration: channel count
	input  wire logic                  cfg_we,
	input  wire logic [COUNT_W-1:0]    cfg_data,
	// request channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  req_type,
	input  wire logic [INDEX_W-1:0]    channel_index,
	input  wire logic [SAMPLE_W-1:0]   sample_value,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PLANE_W-1:0]         plane_word,
	output logic [WORD_NUM_W-1:0]      word_number,
	output logic                       frame_last,
	output logic                       no_channels
);

	dbpfp_cmd_t    cmd;
	dbpfp_status_t status;

	// sequencer: accepts a transfer only when idle, walks fetch and emit phases
	dbpfp_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PLANES_KEPT (PLANES_KEPT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd)
	);

	// store, transpose lanes (shifted one plane per word) and output register
	dbpfp_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.channel_index (channel_index),
		.sample_value  (sample_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.plane_word    (plane_word),
		.word_number   (word_number),
		.frame_last    (frame_last),
		.no_channels   (no_channels)
	);

endmodule

`default_nettype wire
